// File: rtl/apnea_backup_breath_monitor_unit_defines.svh
// Assertion macros shared by the apnea watchdog checker.
`ifndef APNEA_BACKUP_BREATH_MONITOR_UNIT_DEFINES_SVH
`define APNEA_BACKUP_BREATH_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define ABBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define ABBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/abbm_pkg.sv
// Types and constants of the apnea backup breath monitor.
`default_nettype none

package abbm_pkg;

  // Engine state codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MON    = 3'd1;
  localparam logic [2:0] ST_TIMED  = 3'd2;
  localparam logic [2:0] ST_BACKUP = 3'd3;
  localparam logic [2:0] ST_ALARM  = 3'd4;

  // Ventilation modes the engine treats specially
  localparam logic [2:0] MD_UNSUPPORTED = 3'd0;
  localparam logic [2:0] MD_VS          = 3'd2;
  localparam logic [2:0] MD_PSVST       = 3'd4;

  // Breath phases
  localparam logic [1:0] PH_INSP = 2'd1;
  localparam logic [1:0] PH_EXP  = 2'd2;

  // Trigger reasons
  localparam logic [2:0] TR_PRESSURE = 3'd1;
  localparam logic [2:0] TR_FLOW     = 3'd2;
  localparam logic [2:0] TR_TIME     = 3'd3;
  localparam logic [2:0] TR_BACKUP   = 3'd4;

  // Request kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VS_APNEA_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_APNEA_S = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VS_BACKUP_EN = 2'd2;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned LIMIT_S_W  = 10;
  localparam int unsigned DEADLINE_W = 20;

  localparam logic [DEADLINE_W-1:0] MS_PER_S         = 20'd1000;
  localparam logic [DEADLINE_W-1:0] VS_APNEA_RESET   = 20'd20000;
  localparam logic [DEADLINE_W-1:0] LIMIT_MS_RESET   = 20'd20000;
  localparam logic                  VS_BACKUP_RESET  = 1'b1;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic        active;
    logic [2:0]  vent_mode;
    logic [1:0]  phase;
    logic        has_mandatory_interval;
    logic        apnea_time_set;
    logic [31:0] backup_interval_ms;
    logic [2:0]  trigger_reason;
    logic        expiration_ready;
    logic        trigger_accept;
    logic [1:0]  phase_after_trigger;
  } item_t;

  typedef struct packed {
    logic [2:0]  engine_state;
    logic        backup_fired;
  } result_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0] vs_apnea_ms;
    logic [DEADLINE_W-1:0] limit_apnea_ms;
    logic                  vs_backup_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  eng;
    logic [2:0]  last_mode;
    logic [1:0]  last_phase;
    logic [31:0] ref_ms;
    logic        started;
  } eng_state_t;

  localparam eng_state_t ENG_RESET = '{
    eng: ST_IDLE, last_mode: MD_UNSUPPORTED, last_phase: 2'd0, ref_ms: 32'd0, started: 1'b0
  };

endpackage

`default_nettype wire

// File: rtl/abbm_cfg.sv
// Configuration registers of the apnea monitor, deadlines kept in milliseconds.
`default_nettype none

module abbm_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [abbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [abbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output abbm_pkg::cfg_t                         cfg_o
);

  abbm_pkg::cfg_t cfg_q, cfg_d;
  logic [abbm_pkg::DEADLINE_W-1:0] limit_ms;

  // Scale seconds to milliseconds at write time; 1023 s still fits 20 bits.
  assign limit_ms = abbm_pkg::DEADLINE_W'(cfg_data_i[abbm_pkg::LIMIT_S_W-1:0])
                    * abbm_pkg::MS_PER_S;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        abbm_pkg::CFG_VS_APNEA_MS:   cfg_d.vs_apnea_ms    = cfg_data_i;
        abbm_pkg::CFG_LIMIT_APNEA_S: cfg_d.limit_apnea_ms = limit_ms;
        abbm_pkg::CFG_VS_BACKUP_EN:  cfg_d.vs_backup_en   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vs_apnea_ms    <= abbm_pkg::VS_APNEA_RESET;
      cfg_q.limit_apnea_ms <= abbm_pkg::LIMIT_MS_RESET;
      cfg_q.vs_backup_en   <= abbm_pkg::VS_BACKUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/abbm_engine.sv
// Apnea engine: state registers and the single-pass next-state logic.
`default_nettype none

module abbm_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire abbm_pkg::item_t   item_i,
  input  wire abbm_pkg::cfg_t    cfg_i,
  output abbm_pkg::result_t      result_o
);

  abbm_pkg::eng_state_t st_q, st_d;
  logic [31:0] elapsed;
  logic [31:0] deadline;
  logic        unsupported;
  logic        backup_ok;
  logic        fired;

  assign unsupported = !item_i.active || (item_i.vent_mode == abbm_pkg::MD_UNSUPPORTED) ||
                       !(item_i.phase inside {abbm_pkg::PH_INSP, abbm_pkg::PH_EXP}) ||
                       (item_i.has_mandatory_interval && !item_i.apnea_time_set);

  // Backup request allowed once in alarm, during expiration.
  assign backup_ok = (item_i.phase == abbm_pkg::PH_EXP) &&
                     !((item_i.vent_mode == abbm_pkg::MD_VS) && !cfg_i.vs_backup_en) &&
                     (item_i.expiration_ready || (item_i.vent_mode == abbm_pkg::MD_VS) ||
                      item_i.has_mandatory_interval) &&
                     item_i.trigger_accept;

  always_comb begin
    st_d     = st_q;
    fired    = 1'b0;
    elapsed  = '0;
    deadline = '0;
    if (item_i.req_type == abbm_pkg::REQ_TRIGGER) begin
      st_d.eng    = abbm_pkg::ST_MON;
      st_d.ref_ms = item_i.now_ms;
    end else if (unsupported) begin
      st_d = abbm_pkg::ENG_RESET;
    end else if (!st_q.started || (st_q.last_mode != item_i.vent_mode)) begin
      st_d.eng        = abbm_pkg::ST_MON;
      st_d.last_mode  = item_i.vent_mode;
      st_d.last_phase = item_i.phase;
      st_d.ref_ms     = item_i.now_ms;
      st_d.started    = 1'b1;
    end else begin
      // New inspiration: classify; restart ref unless timed mandatory.
      if ((item_i.phase == abbm_pkg::PH_INSP) && (st_q.last_phase != abbm_pkg::PH_INSP)) begin
        case (item_i.trigger_reason)
          abbm_pkg::TR_PRESSURE,
          abbm_pkg::TR_FLOW:   st_d.eng = abbm_pkg::ST_MON;
          abbm_pkg::TR_BACKUP: st_d.eng = (item_i.vent_mode == abbm_pkg::MD_PSVST) ?
                                          abbm_pkg::ST_TIMED : abbm_pkg::ST_BACKUP;
          default: ;
        endcase
        if (!item_i.has_mandatory_interval || (item_i.trigger_reason != abbm_pkg::TR_TIME)) begin
          st_d.ref_ms = item_i.now_ms;
        end
      end
      st_d.last_phase = item_i.phase;
      elapsed = item_i.now_ms - st_d.ref_ms;

      if (item_i.vent_mode == abbm_pkg::MD_PSVST) begin
        if ((item_i.backup_interval_ms != '0) && (elapsed >= item_i.backup_interval_ms) &&
            (item_i.phase == abbm_pkg::PH_EXP) && item_i.trigger_accept) begin
          st_d.eng        = abbm_pkg::ST_TIMED;
          st_d.ref_ms     = item_i.now_ms;
          st_d.last_phase = item_i.phase_after_trigger;
          fired           = 1'b1;
        end
      end else begin
        case (st_d.eng)
          abbm_pkg::ST_MON:    deadline = (item_i.vent_mode == abbm_pkg::MD_VS) ?
                                          32'(cfg_i.vs_apnea_ms) : 32'(cfg_i.limit_apnea_ms);
          abbm_pkg::ST_BACKUP: deadline = item_i.backup_interval_ms;
          default:             deadline = '0;
        endcase
        if ((st_d.eng == abbm_pkg::ST_ALARM) || ((deadline != '0) && (elapsed >= deadline))) begin
          st_d.eng = abbm_pkg::ST_ALARM;
          if (backup_ok) begin
            st_d.eng        = abbm_pkg::ST_BACKUP;
            st_d.ref_ms     = item_i.now_ms;
            st_d.last_phase = item_i.phase_after_trigger;
            fired           = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= abbm_pkg::ENG_RESET;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

  assign result_o.engine_state = st_d.eng;
  assign result_o.backup_fired = fired;

endmodule

`default_nettype wire

// File: rtl/apnea_backup_breath_monitor_unit.sv
// Top level of the apnea backup breath monitor: input register, engine, result register.
//
//  channel   | direction | tdata (low bit up)                               | tuser
//  s_axis    | in        | now_ms, active, vent_mode, phase, mandatory,     | req_type
//            |           | apnea_time_set, backup_interval_ms, reason,      |
//            |           | expiration_ready, trigger_accept, phase_after    |
//  m_axis    | out       | engine_state, backup_fired                       | -
//  cfg       | in        | index/data write, no read-back                   | -
//
// An item passes through the input register and then the result register; one item per cycle
// sustained while m_axis_tready stays high.
// The engine state updates in the cycle an item moves from the input register to the
// result register, so each item sees the state the previous one left.
// Reset (rst_ni low, asynchronous) empties both registers and returns the engine to idle
// and the configuration to its defaults. A stalled result holds the result register; the
// input register still takes one more item, then s_axis_tready drops.
`default_nettype none

module apnea_backup_breath_monitor_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // now_ms[31:0], active[32], vent_mode[35:33], phase[37:36],
  // has_mandatory_interval[38], apnea_time_set[39], backup_interval_ms[71:40],
  // trigger_reason[74:72], expiration_ready[75], trigger_accept[76],
  // phase_after_trigger[78:77], zero pad[79]
  input  wire logic [abbm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type[0]
  input  wire logic                              s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // engine_state[2:0], backup_fired[3], zero pad[7:4]
  output      logic [abbm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [abbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [abbm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  abbm_pkg::item_t   in_item_q, in_item_d;
  logic              in_valid_q;
  abbm_pkg::result_t out_res_q;
  abbm_pkg::result_t eng_res;
  logic              out_valid_q;
  logic              advance;
  logic              in_xfer;
  abbm_pkg::cfg_t    cfg;

  // Move the held item into the result register when that slot is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Unpack the stream word into item fields.
  always_comb begin
    in_item_d.req_type               = s_axis_tuser;
    in_item_d.now_ms                 = s_axis_tdata[31:0];
    in_item_d.active                 = s_axis_tdata[32];
    in_item_d.vent_mode              = s_axis_tdata[35:33];
    in_item_d.phase                  = s_axis_tdata[37:36];
    in_item_d.has_mandatory_interval = s_axis_tdata[38];
    in_item_d.apnea_time_set         = s_axis_tdata[39];
    in_item_d.backup_interval_ms     = s_axis_tdata[71:40];
    in_item_d.trigger_reason         = s_axis_tdata[74:72];
    in_item_d.expiration_ready       = s_axis_tdata[75];
    in_item_d.trigger_accept         = s_axis_tdata[76];
    in_item_d.phase_after_trigger    = s_axis_tdata[78:77];
  end

  // Input register: hold the payload, control bit reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_d;
    end
  end

  abbm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  abbm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (eng_res)
  );

  // Result register: load on advance, drop once the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.backup_fired, out_res_q.engine_state};

endmodule

`default_nettype wire

// File: rtl/abbm_checker.sv
// Port-level checks for the apnea backup breath monitor, bound to the top level.
`default_nettype none
`include "apnea_backup_breath_monitor_unit_defines.svh"

module abbm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [abbm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic [2:0] out_state;
  logic       out_fired;
  logic       out_stall;
  logic       out_backup_st;

  assign out_state     = m_axis_tdata[2:0];
  assign out_fired     = m_axis_tdata[3];
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_backup_st = (out_state == abbm_pkg::ST_TIMED) ||
                         (out_state == abbm_pkg::ST_BACKUP);

  // A stalled result keeps its value.
  `ABBM_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata),
                    "stalled result changed")

  // A fired backup always lands in the timed or backup state.
  `ABBM_ASSERT_NOW(a_fired_state, m_axis_tvalid && out_fired, out_backup_st,
                   "backup fired outside timed or backup state")

  // With the result side stalled and the input side full, no new input is taken.
  `ABBM_ASSERT_NEXT(a_full_stall, out_stall && !s_axis_tready,
                    !s_axis_tready || m_axis_tready || !m_axis_tvalid,
                    "input taken while both stages full")

  // Nothing appears on the result side right after reset release.
  `ABBM_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !m_axis_tvalid, "result valid right after reset")

endmodule

bind apnea_backup_breath_monitor_unit abbm_checker u_abbm_checker (.*);

`default_nettype wire

// File: verif/apnea_backup_breath_monitor_unit_tb.sv
// Self-checking stream testbench for the apnea backup breath monitor unit.
`default_nettype none

module apnea_backup_breath_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abbm_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [2:0] MD_CPAP_PSV  = 3'd3;
  localparam logic [2:0] MD_P_SIMV    = 3'd5;
  localparam logic [1:0] PH_OTHER     = 2'd0;
  localparam logic [1:0] PH_UNKNOWN   = 2'd3;
  localparam logic [2:0] TR_OTHER     = 3'd0;
  localparam logic [2:0] TR_UNLISTED  = 3'd7;

  localparam int unsigned N_SETTINGS     = 7;
  localparam int unsigned ITEMS_PER_SET  = 236;
  localparam int unsigned HOLD_AT        = 400;   // transfers in before the long hold-off
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int unsigned TAIL_CYCLES    = 8;     // input and result registers, plus margin

  typedef struct packed {
    item_t   stim;
    logic    typed;   // expected result written in the row, not predicted
    result_t want;
  } dir_row_t;

  // Block ports, all inputs known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predictor copy of the registers and the engine
  logic [19:0] cfg_vs_ms;
  logic [9:0]  cfg_limit_s;
  logic        cfg_vs_backup;
  logic [2:0]  wd_eng;
  logic [2:0]  wd_mode;
  logic [1:0]  wd_phase;
  logic [31:0] wd_anchor;
  logic        wd_started;

  // Stimulus generator state: the ventilation session being played
  logic [31:0] sim_now;
  logic [2:0]  cur_mode;
  logic [1:0]  cur_phase;
  logic [31:0] cur_bint;
  logic        cur_mand;

  result_t     due_results[$];
  dir_row_t    dir_tab[$];
  int unsigned n_sent, n_checked, n_fired, n_alarm, n_err;
  int unsigned burst_left;
  int unsigned quiet;
  logic        held;

  apnea_backup_breath_monitor_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the predicted watchdog by one item and return the result it causes.
  function automatic result_t apnea_step(input item_t it);
    result_t     r;
    logic [31:0] limit;
    logic [31:0] elapsed;
    r.backup_fired = 1'b0;
    if (it.req_type == REQ_TRIGGER) begin
      // patient trigger: back to monitoring, restart the reference only
      wd_eng    = ST_MON;
      wd_anchor = it.now_ms;
    end else if (!it.active || it.vent_mode == MD_UNSUPPORTED ||
                 (it.phase != PH_INSP && it.phase != PH_EXP) ||
                 (it.has_mandatory_interval && !it.apnea_time_set)) begin
      // anything unsupported drops the whole engine back to reset
      wd_eng     = ST_IDLE;
      wd_mode    = MD_UNSUPPORTED;
      wd_phase   = PH_OTHER;
      wd_anchor  = '0;
      wd_started = 1'b0;
    end else if (!wd_started || wd_mode != it.vent_mode) begin
      wd_eng     = ST_MON;
      wd_mode    = it.vent_mode;
      wd_phase   = it.phase;
      wd_anchor  = it.now_ms;
      wd_started = 1'b1;
    end else begin
      // start of an inspiration
      if (it.phase == PH_INSP && wd_phase != PH_INSP) begin
        if (it.trigger_reason == TR_PRESSURE || it.trigger_reason == TR_FLOW) begin
          wd_eng = ST_MON;
        end else if (it.trigger_reason == TR_BACKUP) begin
          wd_eng = (it.vent_mode == MD_PSVST) ? ST_TIMED : ST_BACKUP;
        end
        if (!it.has_mandatory_interval || it.trigger_reason != TR_TIME) begin
          wd_anchor = it.now_ms;
        end
      end
      wd_phase = it.phase;
      elapsed  = it.now_ms - wd_anchor;
      if (it.vent_mode == MD_PSVST) begin
        if (it.backup_interval_ms != 0 && elapsed >= it.backup_interval_ms &&
            it.phase == PH_EXP && it.trigger_accept) begin
          wd_eng         = ST_TIMED;
          wd_anchor      = it.now_ms;
          wd_phase       = it.phase_after_trigger;
          r.backup_fired = 1'b1;
        end
      end else begin
        if (wd_eng == ST_MON) begin
          limit = (it.vent_mode == MD_VS) ? {12'd0, cfg_vs_ms} : cfg_limit_s * MS_PER_S;
        end else if (wd_eng == ST_BACKUP) begin
          limit = it.backup_interval_ms;
        end else begin
          limit = '0;
        end
        if (wd_eng == ST_ALARM || (limit != 0 && elapsed >= limit)) begin
          wd_eng = ST_ALARM;
          if (it.phase == PH_EXP && !(it.vent_mode == MD_VS && !cfg_vs_backup) &&
              (it.expiration_ready || it.vent_mode == MD_VS || it.has_mandatory_interval) &&
              it.trigger_accept) begin
            wd_eng         = ST_BACKUP;
            wd_anchor      = it.now_ms;
            wd_phase       = it.phase_after_trigger;
            r.backup_fired = 1'b1;
          end
        end
      end
    end
    r.engine_state = wd_eng;
    return r;
  endfunction

  // Build a supported process tick.
  function automatic item_t tick(input logic [31:0] now, input logic [2:0] mode,
                                 input logic [1:0] ph, input logic mand, input logic apt,
                                 input logic [31:0] bint, input logic [2:0] why,
                                 input logic xr, input logic acc, input logic [1:0] pa);
    item_t it;
    it.req_type               = REQ_TICK;
    it.now_ms                 = now;
    it.active                 = 1'b1;
    it.vent_mode              = mode;
    it.phase                  = ph;
    it.has_mandatory_interval = mand;
    it.apnea_time_set         = apt;
    it.backup_interval_ms     = bint;
    it.trigger_reason         = why;
    it.expiration_ready       = xr;
    it.trigger_accept         = acc;
    it.phase_after_trigger    = pa;
    return it;
  endfunction

  task automatic add_row(input item_t it, input logic typed, input logic [2:0] st);
    dir_row_t row;
    row.stim = it;
    row.typed = typed;
    row.want.engine_state = st;
    row.want.backup_fired = 1'b0;
    dir_tab.push_back(row);
  endtask

  // Pick the next random item. Mostly a plausible session: steady mode, alternating
  // phases, time stepping toward and across the deadlines. The rest is patient
  // triggers, ticks with one field broken, and raw noise.
  function automatic item_t next_stim();
    item_t       it;
    logic [95:0] raw;
    logic [31:0] hint;
    int unsigned r, d;
    logic        new_bint;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      raw = {$urandom, $urandom, $urandom};
      it  = raw[79:0];
      return it;
    end
    new_bint = ($urandom_range(0, 99) < 4);
    if ($urandom_range(0, 99) < 3) begin
      cur_mode = 3'($urandom_range(1, 7));
      cur_mand = 1'($urandom_range(0, 1));
      new_bint = 1'b1;
    end
    if (new_bint) begin
      d = $urandom_range(0, 9);
      cur_bint = (d == 0) ? 32'd0 : (d < 3) ? $urandom : $urandom_range(1, 30000);
    end
    if ($urandom_range(0, 99) < 45) begin
      cur_phase = (cur_phase == PH_INSP) ? PH_EXP : PH_INSP;
    end
    // step time on the scale of whichever deadline applies now
    if (cur_mode == MD_PSVST || $urandom_range(0, 9) < 3) begin
      hint = cur_bint;
    end else if (cur_mode == MD_VS) begin
      hint = {12'd0, cfg_vs_ms};
    end else begin
      hint = cfg_limit_s * MS_PER_S;
    end
    if (hint == 0) begin
      hint = 32'd1000;
    end
    d = $urandom_range(0, 99);
    if (d < 40) begin
      sim_now = sim_now + $urandom_range(0, 1500);
    end else if (d < 75) begin
      sim_now = sim_now + $urandom_range(0, hint);
    end else if (d < 92) begin
      sim_now = wd_anchor + hint - 32'd2 + $urandom_range(0, 4);  // hug the boundary
    end else if (d < 94) begin
      sim_now = $urandom;
    end else begin
      sim_now = sim_now + $urandom_range(0, hint) + $urandom_range(0, hint);
    end
    d = $urandom_range(0, 99);
    it = tick(sim_now, cur_mode, cur_phase, cur_mand,
              cur_mand ? 1'b1 : 1'($urandom_range(0, 1)), cur_bint,
              (d < 25) ? TR_PRESSURE : (d < 45) ? TR_FLOW : (d < 65) ? TR_TIME :
              (d < 85) ? TR_BACKUP : 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0),
              2'($urandom_range(0, 3)));
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: it.active = 1'b0;
        1: it.vent_mode = MD_UNSUPPORTED;
        2: it.phase = $urandom_range(0, 1) ? PH_UNKNOWN : PH_OTHER;
        default: begin
          it.has_mandatory_interval = 1'b1;
          it.apnea_time_set = 1'b0;
        end
      endcase
    end else if (r < 18) begin
      it.req_type = REQ_TRIGGER;
    end
    return it;
  endfunction

  // Offer one item and hold it until the transfer; queue its expected result then.
  task automatic offer(input item_t it, input logic typed, input result_t want);
    result_t got;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.phase_after_trigger, it.trigger_accept, it.expiration_ready,
                      it.trigger_reason, it.backup_interval_ms, it.apnea_time_set,
                      it.has_mandatory_interval, it.phase, it.vent_mode, it.active,
                      it.now_ms};
    s_axis_tuser  <= it.req_type;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = apnea_step(it);
    due_results.push_back(typed ? want : got);
    n_sent++;
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  // Drop valid and wait for every queued result, plus the pipeline latency.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_VS_APNEA_MS:   cfg_vs_ms = data;
      CFG_LIMIT_APNEA_S: cfg_limit_s = data[LIMIT_S_W-1:0];
      CFG_VS_BACKUP_EN:  cfg_vs_backup = data[0];
      default: ;
    endcase
  endtask

  // Main sequence: reset, directed rows, then one random chunk per register setting.
  initial begin : stim
    item_t                 it;
    result_t               none;
    logic [CFG_DATA_W-1:0] v_vs, v_limit, v_en;
    int unsigned           set_i, k;

    none = '0;
    n_sent = 0;
    burst_left = 0;
    cfg_vs_ms = VS_APNEA_RESET;
    cfg_limit_s = 10'd20;
    cfg_vs_backup = VS_BACKUP_RESET;
    wd_eng = ST_IDLE;
    wd_mode = MD_UNSUPPORTED;
    wd_phase = PH_OTHER;
    wd_anchor = '0;
    wd_started = 1'b0;
    sim_now = $urandom;
    cur_mode = MD_VS;
    cur_phase = PH_EXP;
    cur_bint = 32'd5000;
    cur_mand = 1'b0;

    // Directed rows, default registers (both deadlines 20 s)
    it = tick(32'd0, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd0, TR_OTHER, 1'b0, 1'b1, PH_EXP);
    it.active = 1'b0;
    add_row(it, 1'b1, ST_IDLE);
    it.active = 1'b1;
    it.now_ms = 32'hFFFF_FFFF;
    it.req_type = REQ_TRIGGER;
    add_row(it, 1'b1, ST_MON);
    // volume support: deadline, alarm, backup, spontaneous breath, unlisted reason
    add_row(tick(32'd1000, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b1, ST_MON);
    add_row(tick(32'd20999, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'd21000, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'd21500, MD_VS, PH_INSP, 1'b0, 1'b0, 32'd5000, TR_PRESSURE, 1'b0, 1'b1,
                 PH_EXP), 1'b0, ST_IDLE);
    add_row(tick(32'd22000, MD_VS, PH_INSP, 1'b0, 1'b0, 32'd5000, TR_UNLISTED, 1'b0, 1'b1,
                 PH_EXP), 1'b0, ST_IDLE);
    add_row(tick(32'd41500, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b0, PH_EXP),
            1'b0, ST_IDLE);
    // backup accepted, controller reports the unknown phase code afterwards
    add_row(tick(32'd41510, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1,
                 PH_UNKNOWN), 1'b0, ST_IDLE);
    add_row(tick(32'd41600, MD_VS, PH_INSP, 1'b0, 1'b0, 32'd5000, TR_BACKUP, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'd46600, MD_VS, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    // unsupported phase, plan and mode
    add_row(tick(32'd47000, MD_VS, PH_OTHER, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b1, ST_IDLE);
    add_row(tick(32'd47000, MD_VS, PH_UNKNOWN, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1,
                 PH_EXP), 1'b1, ST_IDLE);
    add_row(tick(32'd47000, MD_VS, PH_EXP, 1'b1, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b1, ST_IDLE);
    add_row(tick(32'd47000, MD_UNSUPPORTED, PH_EXP, 1'b0, 1'b0, 32'd5000, TR_OTHER, 1'b0, 1'b1,
                 PH_EXP), 1'b1, ST_IDLE);
    // PSV-ST timed backups, then the widest interval across the time wrap
    add_row(tick(32'd100, MD_PSVST, PH_EXP, 1'b0, 1'b0, 32'd500, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b1, ST_MON);
    add_row(tick(32'd600, MD_PSVST, PH_EXP, 1'b0, 1'b0, 32'd500, TR_OTHER, 1'b0, 1'b1,
                 PH_UNKNOWN), 1'b0, ST_IDLE);
    add_row(tick(32'd700, MD_PSVST, PH_INSP, 1'b0, 1'b0, 32'd500, TR_BACKUP, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'hFFFF_FFFF, MD_PSVST, PH_EXP, 1'b0, 1'b0, 32'hFFFF_FFFF, TR_OTHER, 1'b0,
                 1'b1, PH_EXP), 1'b0, ST_IDLE);
    // mandatory plan: time-triggered breath keeps the reference, backup without ready
    add_row(tick(32'd0, MD_P_SIMV, PH_EXP, 1'b1, 1'b1, 32'd0, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b1, ST_MON);
    add_row(tick(32'd100, MD_P_SIMV, PH_INSP, 1'b1, 1'b1, 32'd0, TR_TIME, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'd20000, MD_P_SIMV, PH_EXP, 1'b1, 1'b1, 32'd0, TR_OTHER, 1'b0, 1'b1, PH_EXP),
            1'b0, ST_IDLE);
    add_row(tick(32'd20001, MD_CPAP_PSV, PH_EXP, 1'b0, 1'b0, 32'd0, TR_OTHER, 1'b0, 1'b1,
                 PH_EXP), 1'b1, ST_MON);
    it = tick(32'd0, MD_CPAP_PSV, PH_EXP, 1'b0, 1'b0, 32'd0, TR_OTHER, 1'b0, 1'b1, PH_EXP);
    it.req_type = REQ_TRIGGER;
    add_row(it, 1'b1, ST_MON);
    // every field at its top value: phase code 3 makes it unsupported
    it = '1;
    it.req_type = REQ_TICK;
    add_row(it, 1'b1, ST_IDLE);

    // Hold reset, release away from the rising edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      offer(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
      pace();
    end

    for (set_i = 0; set_i < N_SETTINGS; set_i++) begin
      if (set_i > 0) begin
        // registers change only with the pipeline empty
        settle();
        case (set_i)
          1: begin v_vs = '0; v_limit = '0; v_en = '0; end
          2: begin v_vs = 20'd600000; v_limit = 20'd600; v_en = 20'd1; end
          3: begin v_vs = '1; v_limit = '1; v_en = 20'hFFFFE; end
          5: begin v_vs = 20'd1500; v_limit = 20'd2; v_en = 20'd1; end
          default: begin
            v_vs = 20'($urandom_range(0, 40000));
            v_limit = 20'($urandom_range(0, 40));
            v_en = 20'($urandom_range(0, 1));
          end
        endcase
        write_reg(CFG_VS_APNEA_MS, v_vs);
        write_reg(CFG_LIMIT_APNEA_S, v_limit);
        write_reg(CFG_VS_BACKUP_EN, v_en);
      end
      for (k = 0; k < ITEMS_PER_SET; k++) begin
        offer(next_stim(), 1'b0, none);
        pace();
      end
    end

    // Drain and let the pipeline run dry
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d ticks and triggers through %0d register settings with random pacing",
             n_sent, N_SETTINGS);
    $display("checked %0d results: %0d backup breaths fired, %0d alarm states",
             n_checked, n_fired, n_alarm);
    if (n_err == 0 && due_results.size() == 0) begin
      $display("apnea_backup_breath_monitor_unit_tb OK");
    end else begin
      $display("apnea_backup_breath_monitor_unit_tb NOT OK");
    end
    $finish;
  end

  // Receiver: stall on its own pattern, with one long hold-off so the block fills up
  initial begin : rx
    int unsigned pct, left;
    pct = 0;
    left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (left == 0) begin
        left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 15;
          2: pct = 50;
          default: pct = 85;
        endcase
      end
      left--;
      m_axis_tready <= ($urandom_range(0, 99) >= pct);
    end
  end

  // Compare every result transfer with the oldest expectation
  initial begin
    n_checked = 0;
    n_fired = 0;
    n_alarm = 0;
    n_err = 0;
  end

  always @(posedge clk_i) begin : check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
        n_err++;
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (m_axis_tdata[2:0] != want.engine_state) begin
          $display("%0t: engine_state expected %0d, got %0d", $time, want.engine_state,
                   m_axis_tdata[2:0]);
          n_err++;
        end
        if (m_axis_tdata[3] != want.backup_fired) begin
          $display("%0t: backup_fired expected %0d, got %0d", $time, want.backup_fired,
                   m_axis_tdata[3]);
          n_err++;
        end
        if (m_axis_tdata[7:4] != 4'd0) begin
          $display("%0t: pad bits expected 0, got %h", $time, m_axis_tdata[7:4]);
          n_err++;
        end
        if (m_axis_tdata[3]) begin
          n_fired++;
        end
        if (m_axis_tdata[2:0] == ST_ALARM) begin
          n_alarm++;
        end
      end
    end
  end

  // Watchdog: end the run when neither side has moved a transfer for too long
  initial quiet = 0;

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time, quiet,
               due_results.size());
      $display("apnea_backup_breath_monitor_unit_tb NOT OK");
      $finish;
    end
  end

endmodule

`default_nettype wire

// File: apnea_backup_breath_monitor_unit.f
+incdir+rtl
rtl/abbm_pkg.sv
rtl/abbm_cfg.sv
rtl/abbm_engine.sv
rtl/apnea_backup_breath_monitor_unit.sv
rtl/abbm_checker.sv
verif/apnea_backup_breath_monitor_unit_tb.sv
